// ===== rtl/tcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the colour palette of the text cell to sprite decoder.
// Depends on nothing; every other file imports it.
package tcs_pkg;

  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COLOR_W  = 32;
  localparam int COORD_W  = 9;
  localparam int TEXU_W   = 8;
  localparam int TEXV_W   = 7;
  localparam int OFFSET_W = 8;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [OFFSET_W-1:0] TOP_OFFSET_RST = 8'd11;

  // Characters that never draw a glyph
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // Register indexes
  localparam logic [CFG_AW-3:0] REG_TOP_OFFSET = 1'b0;

  typedef enum logic {
    LAYER_BG = 1'b0,
    LAYER_FG = 1'b1
  } tcs_layer_t;

  typedef struct packed {
    tcs_layer_t           layer;
    logic [COLOR_W-1:0]   color;
    logic [COORD_W-1:0]   x_start;
    logic [COORD_W-1:0]   y_start;
    logic [COORD_W-1:0]   x_end;
    logic [COORD_W-1:0]   y_end;
    logic [TEXU_W-1:0]    tex_u;
    logic [TEXV_W-1:0]    tex_v;
    logic                 last_of_cell;
    logic                 last_of_frame;
  } tcs_rect_t;

  localparam logic [23:0] EGA_RGB [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  // Palette entry reordered to 0xFFBBGGRR
  function automatic logic [COLOR_W-1:0] ega_abgr(input logic [3:0] idx);
    logic [23:0] rgb;
    rgb = EGA_RGB[idx];
    return {8'hFF, rgb[7:0], rgb[15:8], rgb[23:16]};
  endfunction

endpackage

// ===== rtl/tcs_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: text cells in, sprite rectangles out.
// Depends on tcs_pkg.
interface tcs_in_if
  import tcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attribute;
  logic              blink_hidden;

  modport source (output valid, char_code, attribute, blink_hidden, input ready);
  modport sink   (input valid, char_code, attribute, blink_hidden, output ready);
endinterface

interface tcs_out_if
  import tcs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               layer;
  logic [COLOR_W-1:0] color;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic [TEXU_W-1:0]  tex_u;
  logic [TEXV_W-1:0]  tex_v;
  logic               last_of_cell;
  logic               last_of_frame;

  modport source (output valid, layer, color, x_start, y_start, x_end, y_end, tex_u, tex_v,
                  last_of_cell, last_of_frame, input ready);
  modport sink   (input valid, layer, color, x_start, y_start, x_end, y_end, tex_u, tex_v,
                  last_of_cell, last_of_frame, output ready);
endinterface

// ===== rtl/text_cell_to_sprite_core.sv =====
`timescale 1ns / 1ps
// Text cell to sprite rectangle decoder: position counters, colour decode, output stage.
// Depends on tcs_pkg and the channel interfaces in tcs_if.sv.
//
//  channel   direction  handshake            carries
//  in_chan   sink       valid/ready          char_code, attribute, blink_hidden
//  out_chan  source     valid/ready          one rectangle per request
//  cfg (APB) slave      psel/penable/pready  top_offset at byte address 0
//
// A cell is decoded in the cycle it is accepted; its background rectangle appears on
// out_chan the next cycle. A cell with a glyph yields a second request held in a
// pending register, and in_chan is not ready while that request is pending.
// The pending slot and the output register set the rate; a stalled output blocks in_chan.
// Reset puts the counters at the first cell and top_offset at 11; no clearing pass.
module text_cell_to_sprite_core
  import tcs_pkg::*;
#(
  parameter int COLUMNS     = 80,
  parameter int ROWS        = 25,
  parameter int CELL_WIDTH  = 6,
  parameter int CELL_HEIGHT = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  tcs_in_if.sink            in_chan,
  tcs_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PROD_W = 16;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [OFFSET_W-1:0] top_offset_r;
  tcs_rect_t           out_r, out_nxt;
  tcs_rect_t           pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                pend_valid_r, pend_valid_nxt;

  logic                in_ready;
  logic                in_fire;
  logic                out_free;
  logic                cfg_wr;
  logic [CFG_AW-3:0]   cfg_idx;

  logic                blink;
  logic [2:0]          bg_idx;
  logic [3:0]          fg_idx;
  logic                show_fg;
  logic                last_col;
  logic                last_row;
  logic [PROD_W-1:0]   x0_full;
  logic [PROD_W-1:0]   y0_full;
  logic [COORD_W-1:0]  x0, x1, y0, y1;
  tcs_rect_t           bg_rect, fg_rect;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  always_comb begin
    prdata = '0;
    if (cfg_idx == REG_TOP_OFFSET) begin
      prdata = CFG_DW'(top_offset_r);
    end
  end

  // Handshakes
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_ready = !pend_valid_r && out_free;
  assign in_fire  = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;

  // Cell decode
  assign blink   = in_chan.attribute[7];
  assign bg_idx  = in_chan.attribute[6:4];
  assign fg_idx  = in_chan.attribute[3:0];
  assign show_fg = !(blink && in_chan.blink_hidden) && (fg_idx != {1'b0, bg_idx}) &&
                   (in_chan.char_code != CHAR_NUL) && (in_chan.char_code != CHAR_SPACE);

  assign last_col = col_r >= COL_LAST;
  assign last_row = row_r >= ROW_LAST;

  assign x0_full = PROD_W'(col_r) * PROD_W'(CELL_WIDTH);
  assign y0_full = PROD_W'(row_r) * PROD_W'(CELL_HEIGHT) + PROD_W'(top_offset_r);
  assign x0 = x0_full[COORD_W-1:0];
  assign y0 = y0_full[COORD_W-1:0];
  assign x1 = x0 + COORD_W'(CELL_WIDTH);
  assign y1 = y0 + COORD_W'(CELL_HEIGHT);

  always_comb begin
    bg_rect.layer         = LAYER_BG;
    bg_rect.color         = ega_abgr({1'b0, bg_idx});
    bg_rect.x_start       = x0;
    bg_rect.y_start       = y0;
    bg_rect.x_end         = x1;
    bg_rect.y_end         = y1;
    bg_rect.tex_u         = '0;
    bg_rect.tex_v         = '0;
    bg_rect.last_of_cell  = !show_fg;
    bg_rect.last_of_frame = !show_fg && last_col && last_row;

    fg_rect.layer         = LAYER_FG;
    fg_rect.color         = ega_abgr(fg_idx);
    fg_rect.x_start       = x0;
    fg_rect.y_start       = y0;
    fg_rect.x_end         = x1;
    fg_rect.y_end         = y1;
    fg_rect.tex_u         = {in_chan.char_code[4:0], 3'b000};
    fg_rect.tex_v         = {in_chan.char_code[7:5], 4'b0000};
    fg_rect.last_of_cell  = 1'b1;
    fg_rect.last_of_frame = last_col && last_row;
  end

  // Output register and pending foreground
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    if (pend_valid_r && out_free) begin
      out_nxt        = pend_r;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end else if (in_fire) begin
      out_nxt        = bg_rect;
      out_valid_nxt  = 1'b1;
      pend_nxt       = fg_rect;
      pend_valid_nxt = show_fg;
    end
  end

  // Advance the cell position, wrapping after the last cell
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      top_offset_r <= TOP_OFFSET_RST;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_wr && cfg_idx == REG_TOP_OFFSET) begin
        top_offset_r <= pwdata[OFFSET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.layer         = out_r.layer;
  assign out_chan.color         = out_r.color;
  assign out_chan.x_start       = out_r.x_start;
  assign out_chan.y_start       = out_r.y_start;
  assign out_chan.x_end         = out_r.x_end;
  assign out_chan.y_end         = out_r.y_end;
  assign out_chan.tex_u         = out_r.tex_u;
  assign out_chan.tex_v         = out_r.tex_v;
  assign out_chan.last_of_cell  = out_r.last_of_cell;
  assign out_chan.last_of_frame = out_r.last_of_frame;

  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("pending foreground without a request in the output register");

  a_pend_is_fg: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_r.layer == LAYER_FG))
    else $error("pending request is not a foreground");

  a_bg_then_fg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.last_of_cell) |-> pend_valid_r)
    else $error("cell left open with no foreground pending");

  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= COL_LAST) && (row_r <= ROW_LAST))
    else $error("cell position out of range");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_col && last_row) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap after the last cell");

endmodule

// ===== sim/text_cell_to_sprite_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for text_cell_to_sprite_core: directed and random cells in, rectangles
// checked against a cycle-free decoder model. Needs tcs_pkg, tcs_if.sv and the core RTL.
module text_cell_to_sprite_core_tb;
  import tcs_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELL_WIDTH    = 6;
  localparam int CELL_HEIGHT   = 10;
  localparam int PHASE_CELLS   = 180;
  localparam int DRAIN_LIMIT   = 100_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 60;
  localparam int TIMEOUT_NS    = 12_000_000;

  localparam logic [CFG_AW-1:0]   ADDR_TOP_OFFSET = {REG_TOP_OFFSET, 2'b00};
  localparam logic [CFG_AW-1:0]   ADDR_SPARE      = 3'd4;
  localparam logic [OFFSET_W-1:0] OFFSET_AT_RESET = 8'd11;

  localparam logic [23:0] PALETTE [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic [ATTR_W-1:0] attr;
    logic              hidden;
  } text_cell_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  tcs_in_if  in_chan ();
  tcs_out_if out_chan ();

  text_cell_to_sprite_core #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .CELL_WIDTH (CELL_WIDTH),
    .CELL_HEIGHT(CELL_HEIGHT)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Decoder model state
  logic [6:0]          col_pos = '0;
  logic [4:0]          row_pos = '0;
  logic [OFFSET_W-1:0] top_offset = OFFSET_AT_RESET;

  text_cell_t pending_cells [$];
  tcs_rect_t  expected_rects [$];

  int  cells_sent = 0;
  int  cells_taken = 0;
  int  rects_seen = 0;
  int  glyph_rects = 0;
  int  frame_ends = 0;
  int  err_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  logic [OFFSET_W-1:0] mid_offset;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [COLOR_W-1:0] palette_abgr(input logic [3:0] idx);
    logic [31:0] c;
    c = {8'hFF, PALETTE[idx]};
    return (c & 32'hFF00FF00) | ((c & 32'hFF) << 16) | ((c >> 16) & 32'hFF);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic text_cell_t random_cell();
    text_cell_t c;
    int pick;
    pick = $urandom_range(0, 9);
    c.chr = (pick == 0) ? CHAR_NUL : (pick == 1) ? CHAR_SPACE : CHAR_W'($urandom);
    c.attr = ATTR_W'($urandom);
    // force matching colours now and then so the dropped-glyph path gets exercised
    if ($urandom_range(0, 7) == 0) c.attr[3:0] = {1'b0, c.attr[6:4]};
    c.hidden = 1'($urandom);
    return c;
  endfunction

  // Work out the rectangles of one accepted cell and step the position counters
  task automatic decode_cell(input text_cell_t c);
    tcs_rect_t  r;
    logic [2:0] bg;
    logic [3:0] fg;
    logic       glyph;
    logic       col_end;
    logic       row_end;
    bg = c.attr[6:4];
    fg = c.attr[3:0];
    glyph = !(c.attr[7] && c.hidden) && (fg != {1'b0, bg}) &&
            (c.chr != CHAR_NUL) && (c.chr != CHAR_SPACE);
    col_end = int'(col_pos) >= COLUMNS - 1;
    row_end = int'(row_pos) >= ROWS - 1;
    r.layer         = LAYER_BG;
    r.color         = palette_abgr({1'b0, bg});
    r.x_start       = COORD_W'(int'(col_pos) * CELL_WIDTH);
    r.y_start       = COORD_W'(int'(row_pos) * CELL_HEIGHT + int'(top_offset));
    r.x_end         = COORD_W'((int'(col_pos) + 1) * CELL_WIDTH);
    r.y_end         = COORD_W'((int'(row_pos) + 1) * CELL_HEIGHT + int'(top_offset));
    r.tex_u         = '0;
    r.tex_v         = '0;
    r.last_of_cell  = !glyph;
    r.last_of_frame = !glyph && col_end && row_end;
    expected_rects.push_back(r);
    if (glyph) begin
      r.layer         = LAYER_FG;
      r.color         = palette_abgr(fg);
      r.tex_u         = {c.chr[4:0], 3'b000};
      r.tex_v         = {c.chr[7:5], 4'b0000};
      r.last_of_cell  = 1'b1;
      r.last_of_frame = col_end && row_end;
      expected_rects.push_back(r);
      glyph_rects++;
    end
    if (col_end && row_end) frame_ends++;
    if (col_end) begin
      col_pos = '0;
      row_pos = row_end ? '0 : row_pos + 5'd1;
    end else begin
      col_pos = col_pos + 7'd1;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch on rectangle %0d, expected %0h, actual %0h",
                 $time, what, rects_seen, want, got);
    end
  endtask

  task automatic check_rect();
    tcs_rect_t want;
    rects_seen++;
    if (expected_rects.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t ns: rectangle %0d arrived with none expected, expected none, actual %0h",
                 $time, rects_seen, out_chan.color);
      return;
    end
    want = expected_rects.pop_front();
    check_field("layer", 32'(want.layer), 32'(out_chan.layer));
    check_field("color", want.color, out_chan.color);
    check_field("x_start", 32'(want.x_start), 32'(out_chan.x_start));
    check_field("y_start", 32'(want.y_start), 32'(out_chan.y_start));
    check_field("x_end", 32'(want.x_end), 32'(out_chan.x_end));
    check_field("y_end", 32'(want.y_end), 32'(out_chan.y_end));
    check_field("tex_u", 32'(want.tex_u), 32'(out_chan.tex_u));
    check_field("tex_v", 32'(want.tex_v), 32'(out_chan.tex_v));
    check_field("last_of_cell", 32'(want.last_of_cell), 32'(out_chan.last_of_cell));
    check_field("last_of_frame", 32'(want.last_of_frame), 32'(out_chan.last_of_frame));
  endtask

  // Cell driver: predict on each accepted request, then present the next one
  always @(posedge clk) begin
    text_cell_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        nxt.chr    = in_chan.char_code;
        nxt.attr   = in_chan.attribute;
        nxt.hidden = in_chan.blink_hidden;
        decode_cell(nxt);
        cells_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_cells.size() != 0) begin
          nxt = pending_cells.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.char_code    <= nxt.chr;
          in_chan.attribute    <= nxt.attr;
          in_chan.blink_hidden <= nxt.hidden;
          gap_left = gaps_on ? pick_gap() : 0;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Rectangle monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) check_rect();
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_TOP_OFFSET) top_offset = data[OFFSET_W-1:0];
  endtask

  task automatic cfg_read_check(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      err_count++;
      $display("%0t ns: register read at %0h mismatch, expected %0h, actual %0h",
               $time, addr, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_cell(input logic [7:0] chr, input logic [7:0] attr, input logic hidden);
    pending_cells.push_back('{chr: chr, attr: attr, hidden: hidden});
    cells_sent++;
  endtask

  // Hold until every request is taken and every rectangle is back, within a limit
  task automatic wait_drained();
    int waited;
    waited = 0;
    while ((cells_taken != cells_sent || expected_rects.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [OFFSET_W-1:0] offset, input bit gaps, input bit stalls);
    text_cell_t c;
    gaps_on   = gaps;
    stalls_on = stalls;
    cfg_write(ADDR_TOP_OFFSET, {(CFG_DW - OFFSET_W)'($urandom), offset});
    cfg_read_check(ADDR_TOP_OFFSET, CFG_DW'(offset));
    repeat (PHASE_CELLS) begin
      c = random_cell();
      queue_cell(c.chr, c.attr, c.hidden);
    end
    wait_drained();
  endtask

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.char_code    = '0;
    in_chan.attribute    = '0;
    in_chan.blink_hidden = 1'b0;
    out_chan.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    cfg_read_check(ADDR_TOP_OFFSET, CFG_DW'(OFFSET_AT_RESET));

    // Directed cells at the reset offset
    queue_cell(CHAR_NUL, 8'h0F, 1'b0);
    queue_cell(CHAR_SPACE, 8'h1E, 1'b0);
    queue_cell(8'hFF, 8'hFF, 1'b0);
    queue_cell(8'hFF, 8'hFF, 1'b1);
    queue_cell(8'h41, 8'h07, 1'b1);
    queue_cell(8'h41, 8'h77, 1'b0);
    queue_cell(8'h41, 8'h7F, 1'b0);
    queue_cell(8'h41, 8'hF7, 1'b0);
    queue_cell(8'h01, 8'h80, 1'b1);
    // every foreground and background palette entry
    for (int k = 0; k < 16; k++)
      queue_cell(8'(k * 16 + 1), {1'b0, 3'(k + 3), 4'(k)}, 1'($urandom));
    wait_drained();

    // A write to an unused address must leave top_offset alone
    cfg_write(ADDR_SPARE, 32'hFFFF_FFFF);
    cfg_read_check(ADDR_TOP_OFFSET, CFG_DW'(OFFSET_AT_RESET));

    mid_offset = OFFSET_W'($urandom_range(1, 254));
    run_phase(8'd0, 1'b1, 1'b1);
    run_phase(8'd255, 1'b0, 1'b0);
    run_phase(mid_offset, 1'b1, 1'b0);
    run_phase(OFFSET_AT_RESET, 1'b0, 1'b1);

    repeat (20) @(posedge clk);
    if (cells_taken != cells_sent || expected_rects.size() != 0) begin
      err_count++;
      $display("%0t ns: run ended unfinished, expected %0d cells and 0 rectangles pending, "
               , $time, cells_sent,
               "actual %0d cells taken and %0d rectangles pending",
               cells_taken, expected_rects.size());
    end
    $display("Decoded %0d cells over %0d screen wraps: %0d rectangles, %0d with a glyph.",
             cells_taken, frame_ends, rects_seen, glyph_rects);
    $display("Row offsets 11, 0, 255 and %0d, with idle and back-pressure on and off.",
             mid_offset);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout after %0d ns with %0d of %0d cells taken", TIMEOUT_NS, cells_taken,
             cells_sent);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tcs_pkg.sv
rtl/tcs_if.sv
rtl/text_cell_to_sprite_core.sv
sim/text_cell_to_sprite_core_tb.sv
